// ===== rtl/ttb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared constants, entry layout and control structs of the bucketed
// transposition table.
// ----------------------------------------------------------------------------
package ttb_pkg;

	localparam int INDEX_BITS  = 16;
	localparam int BUCKET_WAYS = 4;
	localparam int MATE_BOUND  = 31000;

	localparam int BUCKET_COUNT = 1 << INDEX_BITS;
	localparam int WAY_W        = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;

	localparam logic [5:0] AGE_MASK   = 6'h3F;
	localparam logic [1:0] KIND_MASK  = 2'h3;
	localparam int         AGE_WEIGHT = 4;
	localparam int         AGE_SHIFT  = 2;

	// operation codes
	localparam logic [1:0] MODE_PROBE = 2'd0;
	localparam logic [1:0] MODE_STORE = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// bound kinds
	localparam logic [1:0] KIND_EXACT = 2'd1;
	localparam logic [1:0] KIND_LOWER = 2'd2;
	localparam logic [1:0] KIND_UPPER = 2'd3;

	// configuration port
	localparam int         CFG_ADDR_W     = 3;
	localparam logic [0:0] REG_SEARCH_AGE = 1'b0;

	localparam logic signed [16:0] MATE17 = 17'(MATE_BOUND);
	localparam logic signed [16:0] SAT_HI = 17'sd32767;
	localparam logic signed [16:0] SAT_LO = -17'sd32768;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [15:0] score;
		logic [15:0] move;
		logic [7:0]  depth;
		logic [1:0]  kind;
		logic [5:0]  age;
	} entry_t;

	typedef entry_t [BUCKET_WAYS-1:0] bucket_t;

	typedef struct packed {
		logic [1:0]            mode;
		logic [31:0]           key;
		logic [INDEX_BITS-1:0] index;
		logic [7:0]            depth;
		logic [15:0]           window_low;
		logic [15:0]           window_high;
		logic [15:0]           score;
		logic [1:0]            kind;
		logic [15:0]           move;
		logic [7:0]            ply;
	} item_t;

	typedef struct packed {
		logic        usable;
		logic [15:0] score;
		logic [15:0] move;
	} probe_res_t;

	typedef struct packed {
		logic             en;
		logic [WAY_W-1:0] way;
		entry_t           entry;
	} store_dec_t;

endpackage
`default_nettype wire

// ===== rtl/ttb_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_req_if
// Request channel: one probe, store or clear request per handshake.
// ----------------------------------------------------------------------------
interface ttb_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [63:0]        position_hash;
	logic [7:0]         search_depth;
	logic signed [15:0] window_low;
	logic signed [15:0] window_high;
	logic signed [15:0] score_in;
	logic [1:0]         bound_kind;
	logic [15:0]        move_in;
	logic [7:0]         ply_from_root;

	modport source (
		output valid, mode, position_hash, search_depth, window_low, window_high,
		       score_in, bound_kind, move_in, ply_from_root,
		input  ready
	);
	modport sink (
		input  valid, mode, position_hash, search_depth, window_low, window_high,
		       score_in, bound_kind, move_in, ply_from_root,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/ttb_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_rsp_if
// Response channel: one probe result per handshake.
// ----------------------------------------------------------------------------
interface ttb_rsp_if;
	logic               valid;
	logic               ready;
	logic               score_usable;
	logic signed [15:0] score_out;
	logic [15:0]        move_out;

	modport source (
		output valid, score_usable, score_out, move_out,
		input  ready
	);
	modport sink (
		input  valid, score_usable, score_out, move_out,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/ttb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ttb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/ttb_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_cfg
// APB register block holding the search generation.
// ----------------------------------------------------------------------------
module ttb_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ttb_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                     pwdata,
	output logic      [31:0]                     prdata,
	output logic                                 pready,
	input  wire logic                            age_clr,
	output logic      [5:0]                      search_age
);
	import ttb_pkg::*;

	logic [5:0] age_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (age_clr) begin
			age_q <= '0;
		end else if (wr_en && (paddr[2] == REG_SEARCH_AGE)) begin
			age_q <= pwdata[5:0] & AGE_MASK;
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_SEARCH_AGE) begin
			prdata = {26'b0, age_q};
		end
	end

	assign search_age = age_q;

endmodule
`default_nettype wire

// ===== rtl/ttb_bucket_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_bucket_eval
// Compares all ways of one bucket at once: probe hit and cutoff test,
// store target choice and the new entry with its mate adjustment.
// ----------------------------------------------------------------------------
module ttb_bucket_eval (
	input  wire ttb_pkg::bucket_t    bucket,
	input  wire ttb_pkg::item_t      item,
	input  wire logic [5:0]          search_age,
	output ttb_pkg::probe_res_t      probe,
	output ttb_pkg::store_dec_t      store
);
	import ttb_pkg::*;

	logic              hit;
	entry_t            hit_e;
	logic signed [16:0] st;
	logic signed [16:0] ply17;
	logic signed [16:0] adj;
	logic signed [15:0] adj16;
	logic              ok;

	// probe
	always_comb begin
		hit   = 1'b0;
		hit_e = '0;
		for (int w = 0; w < BUCKET_WAYS; w++) begin
			if (!hit && bucket[w].valid && (bucket[w].key == item.key)) begin
				hit   = 1'b1;
				hit_e = bucket[w];
			end
		end

		st    = $signed({hit_e.score[15], hit_e.score});
		ply17 = $signed({9'b0, item.ply});
		if (st >= MATE17) begin
			adj = st - ply17;
		end else if (st <= -MATE17) begin
			adj = st + ply17;
		end else begin
			adj = st;
		end
		adj16 = adj[15:0];

		case (hit_e.kind)
			KIND_EXACT: ok = 1'b1;
			KIND_LOWER: ok = adj16 >= $signed(item.window_high);
			KIND_UPPER: ok = adj16 <= $signed(item.window_low);
			default:    ok = 1'b0;
		endcase

		probe.usable = hit && (hit_e.depth >= item.depth) && ok;
		probe.score  = probe.usable ? adj16 : 16'd0;
		probe.move   = hit ? hit_e.move : 16'd0;
	end

	// store target
	logic               done;
	logic signed [9:0]  best;
	logic signed [9:0]  rank;
	logic [5:0]         diff;
	logic signed [16:0] sin;
	logic signed [16:0] sadj;
	logic [15:0]        ssat;

	always_comb begin
		done      = 1'b0;
		store.en  = 1'b1;
		store.way = '0;
		best      = 10'sd511;
		rank      = '0;
		diff      = '0;
		for (int w = 0; w < BUCKET_WAYS; w++) begin
			if (!done) begin
				if (!bucket[w].valid) begin
					store.way = WAY_W'(w);
					done      = 1'b1;
				end else if (bucket[w].key == item.key) begin
					if ((item.depth >= bucket[w].depth) || (bucket[w].age != search_age)) begin
						store.way = WAY_W'(w);
					end else begin
						store.en = 1'b0;
					end
					done = 1'b1;
				end else begin
					diff = (search_age - bucket[w].age) & AGE_MASK;
					rank = $signed({2'b0, bucket[w].depth}) -
					       $signed({2'b0, diff, 2'b0});
					if (rank < best) begin
						best      = rank;
						store.way = WAY_W'(w);
					end
				end
			end
		end

		// mate distance towards the table, saturated to 16 bits
		sin = $signed({item.score[15], item.score});
		if (sin >= MATE17) begin
			sadj = sin + ply17;
		end else if (sin <= -MATE17) begin
			sadj = sin - ply17;
		end else begin
			sadj = sin;
		end
		if (sadj > SAT_HI) begin
			ssat = 16'h7FFF;
		end else if (sadj < SAT_LO) begin
			ssat = 16'h8000;
		end else begin
			ssat = sadj[15:0];
		end

		store.entry.valid = 1'b1;
		store.entry.key   = item.key;
		store.entry.score = ssat;
		store.entry.move  = item.move;
		store.entry.depth = item.depth;
		store.entry.kind  = item.kind & KIND_MASK;
		store.entry.age   = search_age & AGE_MASK;
	end

endmodule
`default_nettype wire

// ===== rtl/bucketed_transposition_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bucketed_transposition_table
// Hash table of multi-way buckets with depth/age replacement and mate
// distance adjustment, held in one bucket-wide RAM.
// ----------------------------------------------------------------------------
// usage
// req carries probe, store and clear requests; rsp returns one result per
// probe only. search_age is set through the APB port at byte address 0.
// each request first reads its bucket from the RAM (a registered read), then
// all ways are compared in parallel and a store writes the bucket back; no new
// request is taken until the evaluate step is left.
// a probe result is loaded into the output register at the end of the evaluate
// step. while an unread result is held and the receiver stalls, a further
// probe waits in the evaluate step; stores and clears go on.
// a clear request, and reset itself, run a zeroing sweep over all
// 2^INDEX_BITS buckets of the RAM (65536 by default), one bucket a cycle; no
// request is taken during the sweep, configuration writes are. clear also
// returns search_age to zero.
// ----------------------------------------------------------------------------
module bucketed_transposition_table (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	ttb_req_if.sink                              req,
	ttb_rsp_if.source                            rsp,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ttb_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                     pwdata,
	output logic      [31:0]                     prdata,
	output logic                                 pready
);
	import ttb_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EVAL  = 3'b100
	} state_t;

	state_t                state_q;
	logic [INDEX_BITS-1:0] clr_addr_q;
	item_t                 item_s1;
	item_t                 item_in;
	bucket_t               bucket_rd;
	bucket_t               bucket_wr;
	probe_res_t            probe;
	store_dec_t            store;
	logic [5:0]            search_age;
	logic                  age_clr;
	logic                  accept;
	logic                  out_free;
	logic                  load_out;
	logic                  ram_we;
	logic [INDEX_BITS-1:0] ram_waddr;
	logic [INDEX_BITS-1:0] ram_raddr;
	bucket_t               ram_wdata;

	logic               out_valid_q;
	logic               usable_q;
	logic signed [15:0] score_q;
	logic [15:0]        move_q;

	assign item_in.mode        = req.mode;
	assign item_in.key         = req.position_hash[63:32];
	assign item_in.index       = req.position_hash[INDEX_BITS-1:0];
	assign item_in.depth       = req.search_depth;
	assign item_in.window_low  = req.window_low;
	assign item_in.window_high = req.window_high;
	assign item_in.score       = req.score_in;
	assign item_in.kind        = req.bound_kind;
	assign item_in.move        = req.move_in;
	assign item_in.ply         = req.ply_from_root;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign load_out  = (state_q == ST_EVAL) && (item_s1.mode == MODE_PROBE) && out_free;
	assign age_clr   = (state_q == ST_EVAL) && (item_s1.mode == MODE_CLEAR);

	ttb_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.age_clr    (age_clr),
		.search_age (search_age)
	);

	ttb_bucket_eval u_eval (
		.bucket     (bucket_rd),
		.item       (item_s1),
		.search_age (search_age),
		.probe      (probe),
		.store      (store)
	);

	// bucket with the chosen way replaced
	always_comb begin
		bucket_wr = bucket_rd;
		for (int w = 0; w < BUCKET_WAYS; w++) begin
			if (store.way == WAY_W'(w)) begin
				bucket_wr[w] = store.entry;
			end
		end
	end

	// held address keeps the read data steady while a probe waits
	assign ram_raddr = (state_q == ST_IDLE) ? item_in.index : item_s1.index;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = item_s1.index;
		ram_wdata = bucket_wr;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
			end
			ST_EVAL: begin
				ram_we = (item_s1.mode == MODE_STORE) && store.en;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	ttb_ram #(
		.WIDTH ($bits(bucket_t)),
		.DEPTH (BUCKET_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (bucket_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					case (item_s1.mode)
						MODE_PROBE: begin
							if (out_free) begin
								state_q <= ST_IDLE;
							end
						end
						MODE_CLEAR: begin
							clr_addr_q <= '0;
							state_q    <= ST_CLEAR;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			usable_q <= probe.usable;
			score_q  <= probe.score;
			move_q   <= probe.move;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.score_usable = usable_q;
	assign rsp.score_out    = score_q;
	assign rsp.move_out     = move_q;

	// an accepted request is always evaluated in the following cycle
	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EVAL))
		else $error("request taken but not evaluated next cycle");

	// a result never overwrites one that the receiver has not taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || rsp.ready))
		else $error("result register overwritten while stalled");

	// the table is only written back for a store request
	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (state_q == ST_EVAL)) |-> (item_s1.mode == MODE_STORE))
		else $error("bucket written for a non-store request");

	// the zeroing sweep ends after the last bucket
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CLEAR) && (clr_addr_q == '1)) |=> (state_q == ST_IDLE))
		else $error("clear sweep did not finish at the last bucket");

endmodule
`default_nettype wire
